### rtl/rshs_pkg.sv
// Package for the ray/sphere hit test with sky shading.
// Holds widths, pipeline stage positions, color constants and register codes.
// No dependencies.
`default_nettype none

package rshs_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CW   = COORD_WIDTH;       // coordinate width, signed
  localparam int OCW  = CW + 1;            // origin minus center, signed
  localparam int RW   = CW - 1;            // radius width, unsigned
  localparam int RSQW = 2 * RW;            // radius squared
  localparam int SW   = 2 * CW;            // a = d.d, unsigned
  localparam int BPW  = 2 * CW + 2;        // d.oc, signed
  localparam int BMW  = 2 * CW + 1;        // |d.oc|
  localparam int CCW  = 2 * CW + 3;        // c, signed
  localparam int CMW  = 2 * CW + 2;        // |c|
  localparam int BH   = (BMW + 1) / 2;     // low half of |d.oc|
  localparam int BHW  = BMW - BH;          // high half of |d.oc|
  localparam int CH   = (CMW + 1) / 2;     // low half of |c|
  localparam int CHW  = CMW - CH;          // high half of |c|
  localparam int BSQW = 2 * BMW;           // (d.oc)^2
  localparam int ACW  = SW + CMW;          // a*|c|

  localparam int LW    = CW;               // integer square root of a
  localparam int REMW  = LW + 2;           // square root remainder
  localparam int FRAC  = 16;               // fraction bits of dy/|d|
  localparam int QW    = FRAC + 1;         // quotient bits
  localparam int DREMW = LW + 1;           // divider remainder

  localparam int T17W = FRAC + 2;          // t in units of 2^-17
  localparam int RXW  = FRAC + 3;
  localparam int GXW  = FRAC + 5;
  localparam int SCW  = 18;                // width of the 255.999 scale
  localparam int PRW  = RXW + SCW;
  localparam int PGW  = GXW + SCW;
  localparam int VRW  = 18;
  localparam int VGW  = 21;
  localparam int RCRW = 15;                // reciprocal of 1000 width
  localparam int RCGW = 20;                // reciprocal of 5000 width
  localparam int RSH  = 24;
  localparam int GSH  = 32;
  localparam int PQRW = VRW + RCRW;
  localparam int PQGW = VGW + RCGW;

  localparam int HALF_T17 = 65536;
  localparam int FULL_R   = 262144;
  localparam int FULL_G   = 1310720;
  localparam int SCALE    = 255999;
  localparam int RECIP_R  = 16777;         // floor(2^24 / 1000)
  localparam int RECIP_G  = 858993;        // floor(2^32 / 5000)
  localparam int DIV_R    = 1000;
  localparam int DIV_G    = 5000;

  // Pipeline positions, counted from the input register.
  localparam int ST_IN   = 1;
  localparam int ST_PROD = 2;
  localparam int ST_SUM  = 3;
  localparam int ST_SQ0  = 4;
  localparam int ST_HIT  = ST_SQ0 + 3;
  localparam int ST_DIV0 = ST_SQ0 + LW;
  localparam int ST_COL0 = ST_DIV0 + QW;
  localparam int ST_MUL  = ST_COL0 + 1;
  localparam int ST_RCP  = ST_COL0 + 2;
  localparam int NS      = ST_COL0 + 3;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

### rtl/rshs_ray_if.sv
// Ray channel: valid/ready handshake carrying origin and direction.
// Depends on rshs_pkg.
`default_nettype none

interface rshs_ray_if import rshs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] origin_z;
  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;
  logic signed [CW-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

`default_nettype wire

### rtl/rshs_pix_if.sv
// Pixel channel: valid/ready handshake carrying the color bytes and hit flag.
// Depends on rshs_pkg.
`default_nettype none

interface rshs_pix_if import rshs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       sphere_hit;

  modport source (output valid, red, green, blue, sphere_hit, input ready);
  modport sink   (input valid, red, green, blue, sphere_hit, output ready);
endinterface

`default_nettype wire

### rtl/ray_sphere_hit_sky_shader_core.sv
// Top level of the ray/sphere hit test with sky shading.
// Depends on rshs_pkg, rshs_ray_if and rshs_pix_if.
`default_nettype none

// One ray enters per cycle and one pixel leaves per cycle while the output
// is not stalled. In the pipeline, three stages form oc, the products and
// the dot products, sixteen stages take the integer square root of |d|^2
// one result bit each, seventeen stages divide |dy| by that length one
// quotient bit each, and four stages turn t into color bytes through a
// constant multiply, a reciprocal multiply and a final correction step that
// also picks the hit color. The discriminant test runs beside the square
// root stages and splits the wide products into halves. Every stage has its
// own valid bit and advances whenever it is empty or the stage after it
// advances, so empty slots are squeezed out while the output waits, and a
// stall loses and repeats nothing. The sphere registers sit on an APB-style
// port at byte addresses 0, 4, 8 and 12 and must only be written while no
// ray is in flight.
module ray_sphere_hit_sky_shader_core import rshs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rshs_ray_if.sink               in_ray,
  rshs_pix_if.source             out_pix,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // Configuration registers.
  logic signed [CW-1:0] center_x_r, center_y_r, center_z_r;
  logic        [RW-1:0] radius_r;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= -CW'(4096);
      radius_r   <= RW'(2048);
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_CENTER_X: center_x_r <= pwdata[CW-1:0];
        REG_CENTER_Y: center_y_r <= pwdata[CW-1:0];
        REG_CENTER_Z: center_z_r <= pwdata[CW-1:0];
        REG_RADIUS:   radius_r   <= pwdata[RW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X: prdata = DATA_W'(unsigned'(center_x_r));
      REG_CENTER_Y: prdata = DATA_W'(unsigned'(center_y_r));
      REG_CENTER_Z: prdata = DATA_W'(unsigned'(center_z_r));
      REG_RADIUS:   prdata = DATA_W'(radius_r);
    endcase
  end

  // Stage valids and advance enables. A stage moves when it is empty or when
  // the stage after it moves; the last stage is the output register.
  logic [NS:1] v_r;
  logic [NS:1] v_in;
  logic [NS:1] en;

  assign v_in = {v_r[NS-1:1], in_ray.valid};

  genvar gk;
  generate
    for (gk = 1; gk < NS; gk++) begin : g_en
      assign en[gk] = !v_r[gk] || en[gk+1];
    end
  endgenerate
  assign en[NS] = !v_r[NS] || out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~en) | (v_in & en);
    end
  end

  assign in_ray.ready = en[ST_IN];
  assign out_pix.valid = v_r[NS];

  // Input stage: direction and origin minus center.
  logic signed [CW-1:0]  d_r  [3];
  logic signed [OCW-1:0] oc_r [3];
  logic        [RW-1:0]  rad_r;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      d_r[0] <= in_ray.dir_x;
      d_r[1] <= in_ray.dir_y;
      d_r[2] <= in_ray.dir_z;
      oc_r[0] <= OCW'(in_ray.origin_x) - OCW'(center_x_r);
      oc_r[1] <= OCW'(in_ray.origin_y) - OCW'(center_y_r);
      oc_r[2] <= OCW'(in_ray.origin_z) - OCW'(center_z_r);
      rad_r <= radius_r;
    end
  end

  // Product stage.
  logic signed [2*CW-1:0] dd_r  [3];
  logic signed [2*CW:0]   doc_r [3];
  logic signed [2*CW+1:0] oo_r  [3];
  logic        [RSQW-1:0] rr_r;
  logic signed [CW-1:0]   dy_r;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[i]  <= d_r[i] * d_r[i];
        doc_r[i] <= d_r[i] * oc_r[i];
        oo_r[i]  <= oc_r[i] * oc_r[i];
      end
      rr_r <= rad_r * rad_r;
      dy_r <= d_r[1];
    end
  end

  // Sum stage: a, the half of b and c.
  logic        [SW-1:0]  a_r;
  logic signed [BPW-1:0] bp_r;
  logic signed [CCW-1:0] c_r;
  logic                  sgn_r [ST_SUM:ST_COL0-1];
  logic        [CW-1:0]  ady_r [ST_SUM:ST_DIV0-1];

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      a_r  <= unsigned'(dd_r[0]) + unsigned'(dd_r[1]) + unsigned'(dd_r[2]);
      bp_r <= BPW'(doc_r[0]) + BPW'(doc_r[1]) + BPW'(doc_r[2]);
      c_r  <= CCW'(oo_r[0]) + CCW'(oo_r[1]) + CCW'(oo_r[2])
              - CCW'(signed'({1'b0, rr_r}));
      sgn_r[ST_SUM] <= dy_r[CW-1];
      ady_r[ST_SUM] <= dy_r[CW-1] ? CW'(-dy_r) : CW'(dy_r);
    end
  end

  // The sign travels alongside the square root and the divider, |dy| alongside the square root.
  always_ff @(posedge clk) begin
    for (int k = ST_SUM + 1; k <= ST_COL0 - 1; k++) begin
      if (en[k]) begin
        sgn_r[k] <= sgn_r[k-1];
      end
    end
    for (int k = ST_SUM + 1; k <= ST_DIV0 - 1; k++) begin
      if (en[k]) begin
        ady_r[k] <= ady_r[k-1];
      end
    end
  end

  // Discriminant test. The factor of four cancels, so the ray hits when
  // (d.oc)^2 > a*c. The wide products are built from half-width pieces.
  logic [BMW-1:0]      bm_r;
  logic [CMW-1:0]      cm_r;
  logic [SW-1:0]       am_r;
  logic                cneg_r, cneg2_r, cneg3_r;
  logic [2*BHW-1:0]    bhh_r;
  logic [BHW+BH-1:0]   bhl_r;
  logic [2*BH-1:0]     bll_r;
  logic [SW+CHW-1:0]   ach_r;
  logic [SW+CH-1:0]    acl_r;
  logic [BSQW-1:0]     bsq_r;
  logic [ACW-1:0]      ac_r;
  logic                hit_r [ST_HIT:ST_RCP];

  always_ff @(posedge clk) begin
    if (en[ST_SQ0]) begin
      bm_r   <= bp_r[BPW-1] ? BMW'(-bp_r) : BMW'(bp_r);
      cm_r   <= c_r[CCW-1] ? CMW'(-c_r) : CMW'(c_r);
      cneg_r <= c_r[CCW-1];
      am_r   <= a_r;
    end
    if (en[ST_SQ0+1]) begin
      bhh_r   <= (2*BHW)'(bm_r[BMW-1:BH]) * (2*BHW)'(bm_r[BMW-1:BH]);
      bhl_r   <= (BHW+BH)'(bm_r[BMW-1:BH]) * (BHW+BH)'(bm_r[BH-1:0]);
      bll_r   <= (2*BH)'(bm_r[BH-1:0]) * (2*BH)'(bm_r[BH-1:0]);
      ach_r   <= (SW+CHW)'(am_r) * (SW+CHW)'(cm_r[CMW-1:CH]);
      acl_r   <= (SW+CH)'(am_r) * (SW+CH)'(cm_r[CH-1:0]);
      cneg2_r <= cneg_r;
    end
    if (en[ST_SQ0+2]) begin
      bsq_r   <= (BSQW'(bhh_r) << (2*BH)) + (BSQW'(bhl_r) << (BH+1)) + BSQW'(bll_r);
      ac_r    <= (ACW'(ach_r) << CH) + ACW'(acl_r);
      cneg3_r <= cneg2_r;
    end
    if (en[ST_HIT]) begin
      // With c negative, a*c is at most zero, so any nonzero term wins.
      hit_r[ST_HIT] <= cneg3_r ? ((bsq_r != '0) || (ac_r != '0)) : (bsq_r > ac_r);
    end
    for (int k = ST_HIT + 1; k <= ST_RCP; k++) begin
      if (en[k]) begin
        hit_r[k] <= hit_r[k-1];
      end
    end
  end

  // Integer square root of a, one result bit per stage.
  logic [SW-1:0]   sq_rad_r  [LW];
  logic [REMW-1:0] sq_rem_r  [LW];
  logic [LW-1:0]   sq_root_r [LW];
  logic [SW-1:0]   sq_rad_in  [LW];
  logic [REMW-1:0] sq_rem_in  [LW];
  logic [LW-1:0]   sq_root_in [LW];
  logic [SW-1:0]   sq_rad_nxt  [LW];
  logic [REMW-1:0] sq_rem_nxt  [LW];
  logic [LW-1:0]   sq_root_nxt [LW];

  always_comb begin
    logic [REMW-1:0] remsh;
    logic [REMW-1:0] trial;
    sq_rad_in[0]  = a_r;
    sq_rem_in[0]  = '0;
    sq_root_in[0] = '0;
    for (int i = 1; i < LW; i++) begin
      sq_rad_in[i]  = sq_rad_r[i-1];
      sq_rem_in[i]  = sq_rem_r[i-1];
      sq_root_in[i] = sq_root_r[i-1];
    end
    for (int i = 0; i < LW; i++) begin
      remsh = {sq_rem_in[i][REMW-3:0], sq_rad_in[i][SW-1:SW-2]};
      trial = {sq_root_in[i], 2'b01};
      sq_rad_nxt[i] = sq_rad_in[i] << 2;
      if (remsh >= trial) begin
        sq_rem_nxt[i]  = remsh - trial;
        sq_root_nxt[i] = {sq_root_in[i][LW-2:0], 1'b1};
      end else begin
        sq_rem_nxt[i]  = remsh;
        sq_root_nxt[i] = {sq_root_in[i][LW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LW; i++) begin
      if (en[ST_SQ0+i]) begin
        sq_rad_r[i]  <= sq_rad_nxt[i];
        sq_rem_r[i]  <= sq_rem_nxt[i];
        sq_root_r[i] <= sq_root_nxt[i];
      end
    end
  end

  // Restoring divide of |dy| * 2^16 by the length, one quotient bit per
  // stage. The length is never below |dy|, so the quotient fits in 17 bits
  // and the high numerator bits start out below the divisor.
  logic [DREMW-1:0] dv_rem_r [QW];
  logic [QW-1:0]    dv_low_r [QW];
  logic [QW-1:0]    dv_q_r   [QW];
  logic [LW-1:0]    dv_l_r   [QW];
  logic [DREMW-1:0] dv_rem_in [QW];
  logic [QW-1:0]    dv_low_in [QW];
  logic [QW-1:0]    dv_q_in   [QW];
  logic [LW-1:0]    dv_l_in   [QW];
  logic [DREMW-1:0] dv_rem_nxt [QW];
  logic [QW-1:0]    dv_q_nxt   [QW];

  always_comb begin
    logic [DREMW-1:0] remsh;
    logic             ge;
    dv_rem_in[0] = DREMW'(ady_r[ST_DIV0-1][CW-1:1]);
    dv_low_in[0] = {ady_r[ST_DIV0-1][0], {FRAC{1'b0}}};
    dv_q_in[0]   = '0;
    dv_l_in[0]   = sq_root_r[LW-1];
    for (int j = 1; j < QW; j++) begin
      dv_rem_in[j] = dv_rem_r[j-1];
      dv_low_in[j] = dv_low_r[j-1];
      dv_q_in[j]   = dv_q_r[j-1];
      dv_l_in[j]   = dv_l_r[j-1];
    end
    for (int j = 0; j < QW; j++) begin
      remsh = {dv_rem_in[j][DREMW-2:0], dv_low_in[j][QW-1]};
      ge    = remsh >= {1'b0, dv_l_in[j]};
      dv_rem_nxt[j] = ge ? remsh - {1'b0, dv_l_in[j]} : remsh;
      dv_q_nxt[j]   = {dv_q_in[j][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      if (en[ST_DIV0+j]) begin
        dv_rem_r[j] <= dv_rem_nxt[j];
        dv_low_r[j] <= dv_low_in[j] << 1;
        dv_q_r[j]   <= dv_q_nxt[j];
        dv_l_r[j]   <= dv_l_in[j];
      end
    end
  end

  // Color: t in units of 2^-17, then the blend terms for red and green.
  logic [QW-1:0]   qc;
  logic [T17W-1:0] t17;
  logic [RXW-1:0]  rx_r;
  logic [GXW-1:0]  gx_r;
  logic [PRW-1:0]  pr;
  logic [PGW-1:0]  pg;
  logic [VRW-1:0]  vr_r, vr2_r;
  logic [VGW-1:0]  vg_r, vg2_r;
  logic [PQRW-1:0] pqr;
  logic [PQGW-1:0] pqg;
  logic [7:0]      q0r_r, q0g_r;
  logic [VRW-1:0]  remr;
  logic [VGW-1:0]  remg;
  logic [7:0]      red_r, green_r, blue_r;
  logic            hit_out_r;

  always_comb begin
    // A zero length gives t = 0.5.
    if (dv_l_r[QW-1] == '0) begin
      qc = '0;
    end else if (dv_q_r[QW-1] > QW'(HALF_T17)) begin
      qc = QW'(HALF_T17);
    end else begin
      qc = dv_q_r[QW-1];
    end
    t17 = sgn_r[ST_COL0-1] ? T17W'(HALF_T17) - T17W'(qc) : T17W'(HALF_T17) + T17W'(qc);
  end

  assign pr  = PRW'(SCALE) * PRW'(rx_r);
  assign pg  = PGW'(SCALE) * PGW'(gx_r);
  assign pqr = PQRW'(RECIP_R) * PQRW'(vr_r);
  assign pqg = PQGW'(RECIP_G) * PQGW'(vg_r);
  assign remr = vr2_r - VRW'(q0r_r) * VRW'(DIV_R);
  assign remg = vg2_r - VGW'(q0g_r) * VGW'(DIV_G);

  always_ff @(posedge clk) begin
    if (en[ST_COL0]) begin
      rx_r <= RXW'(FULL_R) - RXW'(t17);
      gx_r <= GXW'(FULL_G) - GXW'(3) * GXW'(t17);
    end
    if (en[ST_MUL]) begin
      vr_r <= pr[SCW+VRW-1:SCW];
      vg_r <= pg[SCW+VGW-1:SCW];
    end
    if (en[ST_RCP]) begin
      q0r_r <= pqr[RSH+7:RSH];
      q0g_r <= pqg[GSH+7:GSH];
      vr2_r <= vr_r;
      vg2_r <= vg_r;
    end
    if (en[NS]) begin
      // The reciprocal estimate is at most one low; one compare fixes it.
      hit_out_r <= hit_r[ST_RCP];
      if (hit_r[ST_RCP]) begin
        red_r   <= 8'd255;
        green_r <= 8'd0;
        blue_r  <= 8'd0;
      end else begin
        red_r   <= q0r_r + 8'(remr >= VRW'(DIV_R));
        green_r <= q0g_r + 8'(remg >= VGW'(DIV_G));
        blue_r  <= 8'd255;
      end
    end
  end

  assign out_pix.red        = red_r;
  assign out_pix.green      = green_r;
  assign out_pix.blue       = blue_r;
  assign out_pix.sphere_hit = hit_out_r;

endmodule

`default_nettype wire
